// File: rtl/bounded_deque_with_search_assert.svh
// ---------------------------------------------------------------------------
// Bounded deque with search: assertion macros
// Shared concurrent assertion forms for the checker of the deque block.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bounded deque assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bounded deque assertion failed");

`endif

// File: rtl/bdq_pkg.sv
// ---------------------------------------------------------------------------
// Bounded deque with search: package
// Operation and status codes, port widths, parameter defaults and the
// sequencer state type shared by the deque files.
// ---------------------------------------------------------------------------
package bdq_pkg;

    // Parameter defaults.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed port widths.
    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd1;
    localparam logic [OP_W-1:0] OP_POP    = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_POP    = 3'b010,
        ST_SEARCH = 3'b100
    } state_t;

endpackage

// File: rtl/bdq_slot_unit.sv
// ---------------------------------------------------------------------------
// Bounded deque with search: slot address unit
// Shared ring address adder: slot = (head + offset) mod DEPTH, for an offset
// of at most DEPTH, with one compare and subtract for the wrap.
// ---------------------------------------------------------------------------
module bdq_slot_unit #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic [$clog2(DEPTH)-1:0]   head_i,
    input  logic [$clog2(DEPTH+1)-1:0] off_i,
    output logic [$clog2(DEPTH)-1:0]   slot_o
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;

    // Add and fold back once into the ring.
    always_comb begin
        sum     = SUM_W'(head_i) + SUM_W'(off_i);
        wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
        slot_o  = wrapped[IDX_W-1:0];
    end

endmodule

// File: rtl/bounded_deque_with_search.sv
// ---------------------------------------------------------------------------
// Bounded deque with search
// Ring store of words usable as a stack or a queue, with a serial search
// over the held entries through one memory read port and one comparator.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_op, s_value
//  m_        out        m_valid/m_ready    m_value_out, m_found, m_status, m_count
//
//  Append, push, clear, unused codes and any request on an empty store load
//  their result on acceptance; a pop of a held entry waits on the registered memory read.
//  A search ends at the first held entry that matches, else after all held
//  entries (one entry read a cycle).
//  Reset is synchronous and needs no clearing pass; the store starts empty.
//  s_ready is low while an operation is in progress and while a result
//  waits on m_ready; a result that is taken frees the block the same cycle.
// ---------------------------------------------------------------------------
module bounded_deque_with_search #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bdq_pkg::OP_W-1:0]            s_op,
    input  logic signed [bdq_pkg::VALUE_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bdq_pkg::VALUE_W-1:0]  m_value_out,
    output logic                                m_found,
    output logic [bdq_pkg::STATUS_W-1:0]        m_status,
    output logic [bdq_pkg::COUNT_W-1:0]         m_count
);

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = bdq_pkg::VALUE_W;
    localparam int COUNT_W = bdq_pkg::COUNT_W;

    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] LAST_OFF = CNT_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);
    localparam logic [IDX_W-1:0] IDX_ZERO = '0;

    // Storage.
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // Control state.
    bdq_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_off_reg, issue_off_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             m_valid_reg, m_valid_next;

    // Request and result payload.
    logic [DATA_WIDTH-1:0]         key_reg, key_next;
    logic [DATA_WIDTH-1:0]         res_value_reg, res_value_next;
    logic                          res_found_reg, res_found_next;
    logic [bdq_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [CNT_W-1:0]              res_count_reg, res_count_next;

    // Datapath signals.
    logic [DATA_WIDTH-1:0] word;
    logic [CNT_W-1:0]      off;
    logic [IDX_W-1:0]      slot;
    logic                  accept;
    logic                  res_load;
    logic                  wr_en;
    logic                  rd_en;
    logic                  full;
    logic                  empty;
    logic                  hit;

    // Request word fitted to the stored width.
    generate
        if (DATA_WIDTH <= VALUE_W) begin : g_word_trunc
            assign word = s_value[DATA_WIDTH-1:0];
        end else begin : g_word_ext
            assign word = {{(DATA_WIDTH - VALUE_W){s_value[VALUE_W-1]}}, s_value};
        end
    endgenerate

    // Shared ring address unit.
    bdq_slot_unit #(
        .DEPTH (DEPTH)
    ) u_slot (
        .head_i (head_reg),
        .off_i  (off),
        .slot_o (slot)
    );

    assign s_ready = (state_reg == bdq_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign hit     = (rd_data_reg == key_reg);

    // Sequencer and next-state logic.
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        issue_off_next  = issue_off_reg;
        remain_next     = remain_reg;
        key_next        = key_reg;
        off             = '0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        res_load        = 1'b0;
        res_value_next  = '0;
        res_found_next  = 1'b0;
        res_status_next = bdq_pkg::STAT_OK;

        unique case (state_reg)
            bdq_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (s_op)
                        bdq_pkg::OP_APPEND: begin
                            off      = count_reg;
                            res_load = 1'b1;
                            if (full) begin
                                res_status_next = bdq_pkg::STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        bdq_pkg::OP_PUSH: begin
                            off      = LAST_OFF;
                            res_load = 1'b1;
                            if (full) begin
                                res_status_next = bdq_pkg::STAT_FULL;
                            end else begin
                                wr_en      = 1'b1;
                                head_next  = slot;
                                count_next = count_reg + ONE_C;
                            end
                        end
                        bdq_pkg::OP_POP: begin
                            if (empty) begin
                                res_load        = 1'b1;
                                res_status_next = bdq_pkg::STAT_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                count_next = count_reg - ONE_C;
                                state_next = bdq_pkg::ST_POP;
                            end
                        end
                        bdq_pkg::OP_SEARCH: begin
                            if (empty) begin
                                res_load = 1'b1;
                            end else begin
                                rd_en          = 1'b1;
                                key_next       = word;
                                issue_off_next = ONE_C;
                                remain_next    = count_reg;
                                state_next     = bdq_pkg::ST_SEARCH;
                            end
                        end
                        bdq_pkg::OP_CLEAR: begin
                            res_load   = 1'b1;
                            head_next  = IDX_ZERO;
                            count_next = '0;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            bdq_pkg::ST_POP: begin
                // Head data has arrived; step the head forward by one.
                off            = ONE_C;
                head_next      = slot;
                res_load       = 1'b1;
                res_value_next = rd_data_reg;
                state_next     = bdq_pkg::ST_IDLE;
            end
            bdq_pkg::ST_SEARCH: begin
                // Compare the entry fetched last cycle and fetch the next one.
                off   = issue_off_reg;
                rd_en = 1'b1;
                if (hit || (remain_reg == ONE_C)) begin
                    res_load       = 1'b1;
                    res_found_next = hit;
                    state_next     = bdq_pkg::ST_IDLE;
                end else begin
                    remain_next    = remain_reg - ONE_C;
                    issue_off_next = issue_off_reg + ONE_C;
                end
            end
            default: begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase

        res_count_next = count_next;

        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bdq_pkg::ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Sequencer counters and payload registers.
    always_ff @(posedge aclk) begin
        issue_off_reg <= issue_off_next;
        remain_reg    <= remain_next;
        key_reg       <= key_next;
        if (res_load) begin
            res_value_reg  <= res_value_next;
            res_found_reg  <= res_found_next;
            res_status_reg <= res_status_next;
            res_count_reg  <= res_count_next;
        end
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[slot] <= word;
        end
        if (rd_en) begin
            rd_data_reg <= mem[slot];
        end
    end

    // Result ports.
    assign m_valid  = m_valid_reg;
    assign m_found  = res_found_reg;
    assign m_status = res_status_reg;

    generate
        if (DATA_WIDTH >= VALUE_W) begin : g_out_trunc
            assign m_value_out = res_value_reg[VALUE_W-1:0];
        end else begin : g_out_ext
            assign m_value_out = {{(VALUE_W - DATA_WIDTH){1'b0}}, res_value_reg};
        end
        if (CNT_W >= COUNT_W) begin : g_cnt_trunc
            assign m_count = res_count_reg[COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign m_count = {{(COUNT_W - CNT_W){1'b0}}, res_count_reg};
        end
    endgenerate

endmodule

// File: rtl/bdq_checker.sv
// ---------------------------------------------------------------------------
// Bounded deque with search: port checker
// Concurrent checks on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "bounded_deque_with_search_assert.svh"

module bdq_checker #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [bdq_pkg::VALUE_W-1:0]  m_value_out,
    input logic                                m_found,
    input logic [bdq_pkg::STATUS_W-1:0]        m_status,
    input logic [bdq_pkg::COUNT_W-1:0]         m_count
);

    localparam int RES_W = bdq_pkg::VALUE_W + 1 + bdq_pkg::STATUS_W + bdq_pkg::COUNT_W;

    logic             status_known;
    logic             res_failed;
    logic             res_clean;
    logic [RES_W-1:0] res_word;

    // Helper terms that keep the assertions short.
    assign status_known = (m_status == bdq_pkg::STAT_OK) ||
                          (m_status == bdq_pkg::STAT_EMPTY) ||
                          (m_status == bdq_pkg::STAT_FULL);
    assign res_failed   = m_valid && (m_status != bdq_pkg::STAT_OK);
    assign res_clean    = (m_value_out == '0) && !m_found;
    assign res_word     = {m_value_out, m_found, m_status, m_count};

    // A result never carries the unused status code.
    `BDQ_ASSERT_IMP(a_status_code, aclk, aresetn, m_valid, status_known)

    // The reported count never exceeds the capacity.
    `BDQ_ASSERT_IMP(a_count_bound, aclk, aresetn, m_valid, (DEPTH > 31) || (m_count <= DEPTH))

    // A failed operation reports neither a popped word nor a match.
    `BDQ_ASSERT_IMP(a_fail_clean, aclk, aresetn, res_failed, res_clean)

    // A stalled result stays put until it is taken.
    `BDQ_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(res_word))

endmodule

bind bounded_deque_with_search bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (.*);
